// ===== rtl/cvp_pkg.sv =====
`default_nettype none
package cvp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int TRIG_BITS     = 14;
    localparam int FOCAL_BITS    = 12;
    localparam int DEPTH_A_NUM   = 10001;
    localparam int DEPTH_DEN     = 9999;
    localparam int DEPTH_B_NUM   = 200;
    localparam int DIV_QUO_W     = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAM_X       = 3'd0,
        CFG_CAM_Y       = 3'd1,
        CFG_CAM_Z       = 3'd2,
        CFG_COS_PITCH   = 3'd3,
        CFG_SIN_PITCH   = 3'd4,
        CFG_COS_YAW     = 3'd5,
        CFG_SIN_YAW     = 3'd6,
        CFG_FOCAL_SCALE = 3'd7
    } t_cfg_idx;

    // per-vertex flags carried alongside the dividers
    typedef struct packed {
        logic nonpos;
        logic x_neg;
        logic x_zero;
        logic y_neg;
        logic y_zero;
        logic last;
    } t_side;

endpackage
`default_nettype wire

// ===== rtl/camera_vertex_projection_core.sv =====
`default_nettype none
// from input transaction to result: 6 arithmetic stages, 33 stages of the restoring
// dividers and one output register, 40 registers in all
// throughput: one vertex per cycle; the whole pipeline holds while a result waits
// reset (synchronous, active low) empties the pipeline and loads the default camera
module camera_vertex_projection_core
    import cvp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic signed [31:0]    i_point_x,
    input  wire logic signed [31:0]    i_point_y,
    input  wire logic signed [31:0]    i_point_z,
    input  wire logic                  i_last_vertex,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic signed [31:0]         o_proj_x,
    output logic signed [31:0]         o_proj_y,
    output logic signed [31:0]         o_proj_depth,
    output logic                       o_visible,
    output logic                       o_last_out
);

    localparam int SH_N   = (FRAC_BITS >= FOCAL_BITS) ? FRAC_BITS - FOCAL_BITS : 0;
    localparam int SH_D   = (FRAC_BITS < FOCAL_BITS) ? FOCAL_BITS - FRAC_BITS : 0;
    localparam int NUM_W  = (48 + SH_N > 8 + 2 * FRAC_BITS) ? 48 + SH_N : 8 + 2 * FRAC_BITS;
    localparam int DEN_W  = (31 + SH_D > 45) ? 31 + SH_D : 45;
    localparam int DIV_LAT = DIV_QUO_W + 1;
    localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;
    localparam logic [63:0] A_Q =
        (64'(DEPTH_A_NUM) * ONE_Q + 64'(DEPTH_DEN / 2)) / 64'(DEPTH_DEN);
    localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

    // configuration
    logic signed [31:0] r_cam_x, r_cam_y, r_cam_z;
    logic signed [15:0] r_cos_pitch, r_sin_pitch, r_cos_yaw, r_sin_yaw;
    logic        [15:0] r_focal;

    logic en;

    // stage 1
    logic               r_v1, r_last1;
    logic signed [32:0] r_lx, r_ly, r_lz;
    // stage 2
    logic               r_v2, r_last2;
    logic signed [48:0] r_cylx, r_sylz, r_cylz, r_sylx;
    logic signed [32:0] r_ly2;
    // stage 3
    logic               r_v3, r_last3;
    logic signed [35:0] r_u3, r_w3;
    logic signed [32:0] r_ly3;
    logic signed [49:0] n_usum, n_wsum;
    // stage 4
    logic               r_v4, r_last4;
    logic signed [48:0] r_cply, r_sply;
    logic signed [51:0] r_spw, r_cpw;
    logic signed [35:0] r_u4;
    // stage 5
    logic               r_v5, r_last5;
    logic signed [31:0] r_rx, r_ry, r_rz;
    logic signed [52:0] n_ysum, n_zsum;
    // stage 6
    logic               r_v6;
    logic        [47:0] r_nx, r_ny;
    logic        [44:0] r_nz;
    logic        [30:0] r_rz6;
    t_side              r_side6;
    logic        [31:0] n_mx, n_my;
    // dividers
    logic [NUM_W-1:0]    n_num_x, n_num_y, n_num_d;
    logic [DEN_W-1:0]    n_den_p, n_den_d;
    logic [DIV_QUO_W-1:0] q_x, q_y, q_d;
    logic                ovf_x, ovf_y, ovf_d;
    logic                r_dv   [0:DIV_LAT-1];
    t_side               r_side [0:DIV_LAT-1];
    // output
    logic signed [31:0] n_px, n_py, n_pd;
    logic signed [33:0] n_diff;

    function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
        if (v[38:31] == {8{v[31]}}) begin
            return v[31:0];
        end else begin
            return v[38] ? INT_MIN : INT_MAX;
        end
    endfunction

    function automatic logic signed [31:0] proj_out(input logic [31:0] q, input logic ovf,
                                                    input t_side s, input logic neg,
                                                    input logic zero);
        logic signed [31:0] res;
        if (s.nonpos) begin
            res = zero ? 32'sd0 : (neg ? INT_MIN : INT_MAX);
        end else if (neg) begin
            res = (ovf || q > 32'h8000_0000) ? INT_MIN : -$signed(q);
        end else begin
            res = (ovf || q[31]) ? INT_MAX : $signed(q);
        end
        return res;
    endfunction

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x     <= '0;
            r_cam_y     <= 32'(ONE_Q);
            r_cam_z     <= -32'(ONE_Q * 64'd3);
            r_cos_pitch <= 16'sd16384;
            r_sin_pitch <= '0;
            r_cos_yaw   <= 16'sd16384;
            r_sin_yaw   <= '0;
            r_focal     <= 16'd5849;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CAM_X:       r_cam_x     <= i_cfg_data;
                CFG_CAM_Y:       r_cam_y     <= i_cfg_data;
                CFG_CAM_Z:       r_cam_z     <= i_cfg_data;
                CFG_COS_PITCH:   r_cos_pitch <= i_cfg_data[15:0];
                CFG_SIN_PITCH:   r_sin_pitch <= i_cfg_data[15:0];
                CFG_COS_YAW:     r_cos_yaw   <= i_cfg_data[15:0];
                CFG_SIN_YAW:     r_sin_yaw   <= i_cfg_data[15:0];
                CFG_FOCAL_SCALE: r_focal     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++) begin
                r_dv[k] <= 1'b0;
            end
            o_out_valid <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_dv[0] <= r_v6;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
            o_out_valid <= r_dv[DIV_LAT-1];
        end
    end

    // rounding sums, half up then floor shift by the trig fraction
    assign n_usum = 50'(r_cylx) + 50'(r_sylz) + 50'sd8192;
    assign n_wsum = 50'(r_cylz) - 50'(r_sylx) + 50'sd8192;
    assign n_ysum = 53'(r_cply) - 53'(r_spw) + 53'sd8192;
    assign n_zsum = 53'(r_sply) + 53'(r_cpw) + 53'sd8192;

    assign n_mx = r_rx[31] ? (~r_rx + 32'd1) : r_rx;
    assign n_my = r_ry[31] ? (~r_ry + 32'd1) : r_ry;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lx    <= 33'(i_point_x) - 33'(r_cam_x);
            r_ly    <= 33'(i_point_y) - 33'(r_cam_y);
            r_lz    <= 33'(i_point_z) - 33'(r_cam_z);
            r_last1 <= i_last_vertex;

            r_cylx  <= r_cos_yaw * r_lx;
            r_sylz  <= r_sin_yaw * r_lz;
            r_cylz  <= r_cos_yaw * r_lz;
            r_sylx  <= r_sin_yaw * r_lx;
            r_ly2   <= r_ly;
            r_last2 <= r_last1;

            r_u3    <= n_usum[49:14];
            r_w3    <= n_wsum[49:14];
            r_ly3   <= r_ly2;
            r_last3 <= r_last2;

            r_cply  <= r_cos_pitch * r_ly3;
            r_sply  <= r_sin_pitch * r_ly3;
            r_spw   <= r_sin_pitch * r_w3;
            r_cpw   <= r_cos_pitch * r_w3;
            r_u4    <= r_u3;
            r_last4 <= r_last3;

            r_rx    <= sat32(39'(r_u4));
            r_ry    <= sat32(n_ysum[52:14]);
            r_rz    <= sat32(n_zsum[52:14]);
            r_last5 <= r_last4;

            r_nx    <= 48'(n_mx) * 48'(r_focal);
            r_ny    <= 48'(n_my) * 48'(r_focal);
            r_nz    <= 45'(DEPTH_DEN) * 45'(r_rz[30:0]);
            r_rz6   <= r_rz[30:0];
            r_side6 <= '{nonpos: (r_rz[31] || r_rz == 32'sd0),
                         x_neg: r_rx[31], x_zero: (r_rx == 32'sd0),
                         y_neg: r_ry[31], y_zero: (r_ry == 32'sd0),
                         last: r_last5};

            r_side[0] <= r_side6;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end

            o_proj_x     <= n_px;
            o_proj_y     <= n_py;
            o_proj_depth <= n_pd;
            o_visible    <= !r_side[DIV_LAT-1].nonpos && (n_pd <= $signed(32'(ONE_Q)));
            o_last_out   <= r_side[DIV_LAT-1].last;
        end
    end

    assign n_num_x = NUM_W'(r_nx) << SH_N;
    assign n_num_y = NUM_W'(r_ny) << SH_N;
    assign n_den_p = DEN_W'(r_rz6) << SH_D;
    assign n_num_d = NUM_W'(DEPTH_B_NUM) << (2 * FRAC_BITS);
    assign n_den_d = DEN_W'(r_nz);

    cvp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(DIV_QUO_W)) u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (n_num_x),
        .i_den (n_den_p),
        .o_quo (q_x),
        .o_ovf (ovf_x)
    );

    cvp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(DIV_QUO_W)) u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (n_num_y),
        .i_den (n_den_p),
        .o_quo (q_y),
        .o_ovf (ovf_y)
    );

    cvp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(DIV_QUO_W)) u_div_d (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (n_num_d),
        .i_den (n_den_d),
        .o_quo (q_d),
        .o_ovf (ovf_d)
    );

    assign n_px = proj_out(q_x, ovf_x, r_side[DIV_LAT-1], r_side[DIV_LAT-1].x_neg,
                           r_side[DIV_LAT-1].x_zero);
    assign n_py = proj_out(q_y, ovf_y, r_side[DIV_LAT-1], r_side[DIV_LAT-1].y_neg,
                           r_side[DIV_LAT-1].y_zero);

    // normalized depth: constant minus the truncated depth term
    assign n_diff = $signed(34'(A_Q[32:0])) - $signed(34'(q_d));

    always_comb begin
        if (r_side[DIV_LAT-1].nonpos) begin
            n_pd = INT_MAX;
        end else if (ovf_d || (n_diff < $signed(34'(INT_MIN)))) begin
            n_pd = INT_MIN;
        end else begin
            n_pd = n_diff[31:0];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/cvp_div.sv =====
`default_nettype none
module cvp_div
    import cvp_pkg::*;
#(
    parameter int NUM_W = 60,
    parameter int DEN_W = 45,
    parameter int QUO_W = DIV_QUO_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [QUO_W-1:0] o_quo,
    output logic                  o_ovf
);

    localparam int W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [W-1:0]     r_rem [0:QUO_W];
    logic [DEN_W-1:0] r_den [0:QUO_W];
    logic [QUO_W-1:0] r_quo [0:QUO_W];
    logic             r_ovf [0:QUO_W];

    // quotient that does not fit in QUO_W bits is flagged up front
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= W'(i_num);
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= (W'(i_num) >= (W'(i_den) << QUO_W));
        end
    end

    for (genvar j = 1; j <= QUO_W; j++) begin : g_step
        localparam int K = QUO_W - j;
        logic [W:0] n_trial;
        assign n_trial = {1'b0, r_rem[j-1]} - ((W+1)'(r_den[j-1]) << K);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[j] <= r_den[j-1];
                r_ovf[j] <= r_ovf[j-1];
                if (!n_trial[W]) begin
                    r_rem[j] <= n_trial[W-1:0];
                    r_quo[j] <= r_quo[j-1] | (QUO_W'(1) << K);
                end else begin
                    r_rem[j] <= r_rem[j-1];
                    r_quo[j] <= r_quo[j-1];
                end
            end
        end
    end

    assign o_quo = r_quo[QUO_W];
    assign o_ovf = r_ovf[QUO_W];

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none
module tb;
    import cvp_pkg::*;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic               last;
    } t_vertex;

    typedef struct {
        logic signed [31:0] proj_x;
        logic signed [31:0] proj_y;
        logic signed [31:0] proj_depth;
        logic               visible;
        logic               last_out;
    } t_projection;

    localparam int FB = FRAC_BITS_DEF;
    localparam longint I32MAX = 64'sd2147483647;
    localparam longint I32MIN = -64'sd2147483648;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [31:0] i_point_x = '0, i_point_y = '0, i_point_z = '0;
    logic i_last_vertex = 1'b0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [31:0] o_proj_x, o_proj_y, o_proj_depth;
    logic o_visible, o_last_out;

    camera_vertex_projection_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_point_x(i_point_x), .i_point_y(i_point_y), .i_point_z(i_point_z),
        .i_last_vertex(i_last_vertex),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_proj_x(o_proj_x), .o_proj_y(o_proj_y), .o_proj_depth(o_proj_depth),
        .o_visible(o_visible), .o_last_out(o_last_out)
    );

    always #6 i_clk = ~i_clk;

    // camera registers as the predictor sees them
    logic signed [31:0] cam_x, cam_y, cam_z;
    logic signed [15:0] cos_p, sin_p, cos_y, sin_y;
    logic [15:0] focal;

    t_vertex     pending_vertices[$];
    t_projection expected_proj[$];
    int          mismatches = 0;
    int          accepted = 0;
    int          queued = 0;

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint trig_round(longint v);
        return floor_sh(v + (64'sd1 <<< (TRIG_BITS - 1)), TRIG_BITS);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > I32MAX) return I32MAX;
        if (v < I32MIN) return I32MIN;
        return v;
    endfunction

    function automatic longint rail(longint v);
        if (v > 0) return I32MAX;
        if (v < 0) return I32MIN;
        return 0;
    endfunction

    function automatic longint perspective_div(longint c, longint z);
        longint num;
        num = (c * longint'(focal)) * (64'sd1 <<< (FB - FOCAL_BITS));
        return clamp32(num / z);
    endfunction

    function automatic t_projection project_vertex(t_vertex v);
        t_projection r;
        longint lx, ly, lz, cp, sp, cy, sy, u, w, rx, ry, rz, aq, term, pd;
        lx = longint'(v.px) - longint'(cam_x);
        ly = longint'(v.py) - longint'(cam_y);
        lz = longint'(v.pz) - longint'(cam_z);
        cp = cos_p; sp = sin_p; cy = cos_y; sy = sin_y;
        u = trig_round(cy * lx + sy * lz);
        w = trig_round(cy * lz - sy * lx);
        rx = clamp32(u);
        ry = clamp32(trig_round(cp * ly - sp * w));
        rz = clamp32(trig_round(sp * ly + cp * w));
        r.last_out = v.last;
        if (rz <= 0) begin
            r.proj_x = 32'(rail(rx));
            r.proj_y = 32'(rail(ry));
            r.proj_depth = 32'(I32MAX);
            r.visible = 1'b0;
        end else begin
            aq = (DEPTH_A_NUM * (64'sd1 <<< FB) + DEPTH_DEN / 2) / DEPTH_DEN;
            term = (DEPTH_B_NUM * (64'sd1 <<< (2 * FB))) / (DEPTH_DEN * rz);
            r.proj_x = 32'(perspective_div(rx, rz));
            r.proj_y = 32'(perspective_div(ry, rz));
            pd = clamp32(aq - term);
            r.proj_depth = 32'(pd);
            r.visible = (pd <= (64'sd1 <<< FB));
        end
        return r;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_CAM_X:       cam_x = val;
            CFG_CAM_Y:       cam_y = val;
            CFG_CAM_Z:       cam_z = val;
            CFG_COS_PITCH:   cos_p = val[15:0];
            CFG_SIN_PITCH:   sin_p = val[15:0];
            CFG_COS_YAW:     cos_y = val[15:0];
            CFG_SIN_YAW:     sin_y = val[15:0];
            CFG_FOCAL_SCALE: focal = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic l);
        t_vertex v;
        v.px = x; v.py = y; v.pz = z; v.last = l;
        pending_vertices.push_back(v);
        queued++;
    endtask

    task automatic drain_and_settle();
        while (accepted < queued || expected_proj.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_trig();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 32'(16'sh4000);
        if (k == 1) return 32'(-16'sh4000);
        if (k == 2) return 32'($urandom_range(0, 65535));
        return 32'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic logic [31:0] rand_coord();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6) return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
        if (k < 8) return $urandom;
        if (k == 8) return 32'h7fffffff;
        return 32'h80000000;
    endfunction

    // driver: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_vertex v;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_proj.push_back(project_vertex(pending_vertices.pop_front()));
                accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_vertices.size() != 0) begin
                    v = pending_vertices[0];
                    i_in_valid <= 1'b1;
                    i_point_x <= v.px;
                    i_point_y <= v.py;
                    i_point_z <= v.pz;
                    i_last_vertex <= v.last;
                    if (burst_left > 0) burst_left--;
                    else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor with its own stall pattern
    int stall_phase = 0;
    always @(posedge i_clk) begin
        t_projection e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_proj.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction at %0t", $realtime);
            end else begin
                e = expected_proj.pop_front();
                if (o_proj_x !== e.proj_x || o_proj_y !== e.proj_y ||
                    o_proj_depth !== e.proj_depth || o_visible !== e.visible ||
                    o_last_out !== e.last_out) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp x=%0d y=%0d d=%0d v=%b l=%b ",
                                  "got x=%0d y=%0d d=%0d v=%b l=%b"},
                                 e.proj_x, e.proj_y, e.proj_depth, e.visible, e.last_out,
                                 o_proj_x, o_proj_y, o_proj_depth, o_visible, o_last_out);
                end
            end
        end
        stall_phase <= stall_phase + 1;
        case ((stall_phase / 256) % 3)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 3) != 0);
            default: i_out_ready <= ((stall_phase % 7) < 3);
        endcase
    end

    initial begin
        int n, ph;
        cam_x = 0; cam_y = 32'sh10000; cam_z = -32'sh30000;
        cos_p = 16'sd16384; sin_p = '0; cos_y = 16'sd16384; sin_y = '0; focal = 16'd5849;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (60) @(posedge i_clk);

        // directed: default camera
        add_vertex(0, 0, 0, 0);
        add_vertex(0, 32'sh10000, -32'sh30000, 1);
        add_vertex(0, 0, -32'sh40000, 0);
        add_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1);
        add_vertex(32'h80000000, 32'h80000000, 32'h80000000, 0);
        add_vertex(32'h80000000, 32'h7fffffff, 32'h7fffffff, 1);
        add_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
        add_vertex(32'h10000, 32'h10000, -32'sh2ffff, 0);
        add_vertex(0, 32'sh10000, -32'sh20000, 1);
        add_vertex(32'hffffffff, 32'h0, 32'h0, 0);
        add_vertex(32'h55555555, 32'haaaaaaaa, 32'h12345678, 1);
        add_vertex(32'haaaaaaaa, 32'h55555555, 32'h7fff0000, 0);
        add_vertex(0, 32'sh10000, -32'sh2fd71, 1);
        drain_and_settle();

        // directed: extreme registers
        write_reg(CFG_CAM_X, 32'h7fffffff);
        write_reg(CFG_CAM_Y, 32'h80000000);
        write_reg(CFG_CAM_Z, 32'h80000000);
        write_reg(CFG_COS_PITCH, 32'(-16'sd16384));
        write_reg(CFG_SIN_PITCH, 32'd16384);
        write_reg(CFG_COS_YAW, 32'h7fff);
        write_reg(CFG_SIN_YAW, 32'h8000);
        write_reg(CFG_FOCAL_SCALE, 32'hffff);
        add_vertex(32'h80000000, 32'h7fffffff, 32'h7fffffff, 1);
        add_vertex(0, 0, 0, 0);
        add_vertex(32'h7fffffff, 32'h80000000, 32'h80000000, 1);
        add_vertex(32'h12345678, 32'h87654321, 32'h0badcafe, 0);
        drain_and_settle();
        write_reg(CFG_FOCAL_SCALE, 32'h0);
        write_reg(CFG_COS_YAW, 32'd16384);
        write_reg(CFG_SIN_YAW, 32'(-16'sd16384));
        add_vertex(32'h100000, 32'h200000, 32'h300000, 1);
        add_vertex(32'h80000000, 0, 32'h7fffffff, 0);
        drain_and_settle();

        // random phases
        for (ph = 0; ph < 11; ph++) begin
            if (ph == 0) begin
                write_reg(CFG_CAM_X, 0);
                write_reg(CFG_CAM_Y, 32'sh10000);
                write_reg(CFG_CAM_Z, -32'sh30000);
                write_reg(CFG_COS_PITCH, 16384);
                write_reg(CFG_SIN_PITCH, 0);
                write_reg(CFG_COS_YAW, 16384);
                write_reg(CFG_SIN_YAW, 0);
                write_reg(CFG_FOCAL_SCALE, 5849);
            end else begin
                write_reg(CFG_CAM_X, ($urandom_range(0, 4) == 0) ? $urandom :
                          32'($signed($urandom_range(0, 8 << 16)) - (4 << 16)));
                write_reg(CFG_CAM_Y, ($urandom_range(0, 4) == 0) ? $urandom :
                          32'($signed($urandom_range(0, 8 << 16)) - (4 << 16)));
                write_reg(CFG_CAM_Z, ($urandom_range(0, 4) == 0) ? $urandom :
                          32'($signed($urandom_range(0, 8 << 16)) - (12 << 16)));
                write_reg(CFG_COS_PITCH, rand_trig());
                write_reg(CFG_SIN_PITCH, rand_trig());
                write_reg(CFG_COS_YAW, rand_trig());
                write_reg(CFG_SIN_YAW, rand_trig());
                write_reg(CFG_FOCAL_SCALE, ($urandom_range(0, 5) == 0) ?
                          32'($urandom_range(0, 65535)) : 32'($urandom_range(2000, 12000)));
            end
            for (n = 0; n < 100; n++)
                add_vertex(rand_coord(), rand_coord(), rand_coord(),
                           1'($urandom_range(0, 1)));
            drain_and_settle();
        end
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire
